[rtl/brc_pkg.sv]
// Shared types and constants for the barometer compensation block.
package brc_pkg;

    // Sequencer step codes.
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_T0    = 5'd1;
    localparam logic [4:0] ST_T1    = 5'd2;
    localparam logic [4:0] ST_T2    = 5'd3;
    localparam logic [4:0] ST_T3    = 5'd4;
    localparam logic [4:0] ST_P0    = 5'd5;
    localparam logic [4:0] ST_P1    = 5'd6;
    localparam logic [4:0] ST_P2    = 5'd7;
    localparam logic [4:0] ST_P3    = 5'd8;
    localparam logic [4:0] ST_P4    = 5'd9;
    localparam logic [4:0] ST_P5    = 5'd10;
    localparam logic [4:0] ST_P6    = 5'd11;
    localparam logic [4:0] ST_DIV   = 5'd12;
    localparam logic [4:0] ST_Q0    = 5'd13;
    localparam logic [4:0] ST_Q1    = 5'd14;
    localparam logic [4:0] ST_Q2    = 5'd15;
    localparam logic [4:0] ST_Q3    = 5'd16;
    localparam logic [4:0] ST_OUT   = 5'd17;

    // Register indexes.
    localparam logic [2:0] REG_T1   = 3'd0;
    localparam logic [2:0] REG_T2   = 3'd1;
    localparam logic [2:0] REG_T3   = 3'd2;
    localparam logic [2:0] REG_P1   = 3'd3;
    localparam logic [2:0] REG_P23  = 3'd4;
    localparam logic [2:0] REG_P45  = 3'd5;
    localparam logic [2:0] REG_P67  = 3'd6;
    localparam logic [2:0] REG_P89  = 3'd7;

    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_FULL  = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;

    typedef logic [63:0] word_t;

    // Control from the sequencer to the divider.
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

endpackage

[rtl/brc_mul.sv]
// Shared 64x64 modulo multiplier built from three 32x32 partial products.
module brc_mul
    import brc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  word_t op_a,
    input  word_t op_b,
    output logic  done,
    output word_t product
);
    logic [1:0]  step_reg;
    logic        busy_reg;
    word_t       a_reg, b_reg, acc_reg;
    logic [31:0] ma, mb;
    logic [63:0] pp;

    // Pick one partial product a cycle; only low 64 bits are kept.
    always_comb begin
        case (step_reg)
            2'd0: begin ma = a_reg[31:0];  mb = b_reg[31:0];  end
            2'd1: begin ma = a_reg[63:32]; mb = b_reg[31:0];  end
            2'd2: begin ma = a_reg[31:0];  mb = b_reg[63:32]; end
            default: begin ma = a_reg[31:0]; mb = b_reg[31:0]; end
        endcase
        pp = 64'(ma) * 64'(mb);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
                acc_reg  <= '0;
                a_reg    <= op_a;
                b_reg    <= op_b;
            end else if (busy_reg) begin
                if (step_reg == 2'd0) begin
                    acc_reg <= pp;
                end else begin
                    acc_reg <= acc_reg + {pp[31:0], 32'd0};
                end
                if (step_reg == 2'd2) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                step_reg <= step_reg + 2'd1;
            end
        end
    end

    assign product = acc_reg;
endmodule

[rtl/brc_div.sv]
// Radix-2 restoring divider for signed 64-bit operands, truncating toward zero.
module brc_div
    import brc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output logic     done,
    output word_t    quotient
);
    logic [6:0] cnt_reg;
    logic       busy_reg, neg_reg;
    word_t      rem_reg, quo_reg, den_reg;
    logic [64:0] trial;

    assign trial = {rem_reg, quo_reg[63]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                rem_reg  <= '0;
                quo_reg  <= req.dividend[63] ? -req.dividend : req.dividend;
                den_reg  <= req.divisor[63] ? -req.divisor : req.divisor;
                neg_reg  <= req.dividend[63] ^ req.divisor[63];
            end else if (busy_reg) begin
                // One quotient bit a cycle.
                if (!trial[64]) begin
                    rem_reg <= trial[63:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[62:0], quo_reg[63]};
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quotient = neg_reg ? -quo_reg : quo_reg;
endmodule

[rtl/barometer_raw_compensation_top.sv]
// Top level of the barometer raw compensation block.
// Usage:
//   s_axis carries one raw conversion word: tdata[19:0] raw_sample,
//   tuser mode (0 temperature, 1 pressure). m_axis returns one word for
//   each: tdata[32:0] value, tuser zero_divisor.
//   Coefficients are written through cfg_we/cfg_addr/cfg_wdata while idle.
// Sequence: each product on the shared multiplier is issued, built from three
//   partial products, then taken. A temperature word needs four products;
//   a pressure word ten products and the one-bit-per-cycle divider, or
//   seven products and no divide when the divisor is zero.
//   One word is in flight at a time; s_axis_tready is low while it works.
// Reset: synchronous active-low aresetn clears the coefficients, the stored
//   fine temperature and the sequencer.
// Stall: the result waits in the output register until m_axis_tready; the
//   next input word is taken in the cycle after the result leaves or later.
module barometer_raw_compensation_top
    import brc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // raw_sample[19:0], zero fill
    input  logic        s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // value[32:0], zero fill
    output logic        m_axis_tuser   // zero_divisor
);
    logic [15:0] t1_reg, t2_reg, t3_reg, p1_reg;
    logic [31:0] p23_reg, p45_reg, p67_reg, p89_reg;
    logic [31:0] fine_reg;
    logic [4:0]  state_reg;
    logic [19:0] adc_reg;
    word_t       x_reg, y_reg, z_reg, w_reg;
    logic [32:0] out_value_reg;
    logic        out_zd_reg, out_valid_reg;
    logic        mul_start, mul_done, mul_take, div_done, waiting_reg;
    word_t       mul_a, mul_b, mul_p, div_q;
    word_t       fine_sum, temp_round;
    div_req_t    div_req;

    brc_mul u_mul (.aclk, .aresetn, .start(mul_start), .op_a(mul_a), .op_b(mul_b),
                   .done(mul_done), .product(mul_p));
    brc_div u_div (.aclk, .aresetn, .req(div_req), .done(div_done), .quotient(div_q));

    function automatic word_t sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic word_t asr(input word_t v, input logic [5:0] n);
        return word_t'($signed(v) >>> n);
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_value_reg};
    assign m_axis_tuser  = out_zd_reg;

    // Operands for the multiply each step issues.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_T0: begin mul_a = x_reg; mul_b = sx16(t2_reg); end
            ST_T1: begin mul_a = y_reg; mul_b = y_reg; end
            ST_T2: begin mul_a = asr(mul_p, 6'd12); mul_b = sx16(t3_reg); end
            ST_T3: begin mul_a = z_reg; mul_b = 64'd5; end
            ST_P0: begin mul_a = x_reg; mul_b = x_reg; end
            ST_P1: begin mul_a = w_reg; mul_b = sx16(p67_reg[15:0]); end
            ST_P2: begin mul_a = x_reg; mul_b = sx16(p45_reg[31:16]); end
            ST_P3: begin mul_a = w_reg; mul_b = sx16(p23_reg[31:16]); end
            ST_P4: begin mul_a = x_reg; mul_b = sx16(p23_reg[15:0]); end
            ST_P5: begin mul_a = z_reg; mul_b = {48'd0, p1_reg}; end
            ST_P6: begin mul_a = w_reg; mul_b = PRESS_SCALE; end
            ST_Q0: begin mul_a = sx16(p89_reg[31:16]); mul_b = asr(x_reg, 6'd13); end
            ST_Q1: begin mul_a = mul_p; mul_b = asr(x_reg, 6'd13); end
            ST_Q2: begin mul_a = sx16(p89_reg[15:0]); mul_b = x_reg; end
            default: ;
        endcase
    end

    // Each multiply step issues once, then waits for the product.
    assign mul_start = !waiting_reg && (state_reg inside {ST_T0, ST_T1, ST_T2, ST_T3,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_Q0, ST_Q1, ST_Q2});
    assign mul_take  = waiting_reg && mul_done;

    // Temperature sums taken from the product.
    assign fine_sum   = z_reg + asr(mul_p, 6'd14);
    assign temp_round = asr(mul_p + 64'd128, 6'd8);

    always_comb begin
        div_req.start    = (state_reg == ST_P6) && mul_take && (z_reg != '0);
        div_req.dividend = mul_p;
        div_req.divisor  = z_reg;
    end

    // Coefficient registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= '0; t2_reg <= '0; t3_reg <= '0; p1_reg <= '0;
            p23_reg <= '0; p45_reg <= '0; p67_reg <= '0; p89_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_T1:  t1_reg  <= cfg_wdata[15:0];
                REG_T2:  t2_reg  <= cfg_wdata[15:0];
                REG_T3:  t3_reg  <= cfg_wdata[15:0];
                REG_P1:  p1_reg  <= cfg_wdata[15:0];
                REG_P23: p23_reg <= cfg_wdata;
                REG_P45: p45_reg <= cfg_wdata;
                REG_P67: p67_reg <= cfg_wdata;
                REG_P89: p89_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer. Register roles vary by step; comments name what they hold.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            waiting_reg   <= 1'b0;
            fine_reg      <= '0;
        end else begin
            if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;
            if (mul_start) waiting_reg <= 1'b1;
            else if (mul_take) waiting_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        adc_reg <= s_axis_tdata[19:0];
                        if (!s_axis_tuser) begin
                            // a = adc>>3 - 2*T1 ; b = adc>>4 - T1
                            x_reg <= {47'd0, s_axis_tdata[19:3]} - {47'd0, t1_reg, 1'b0};
                            y_reg <= {48'd0, s_axis_tdata[19:4]} - {48'd0, t1_reg};
                            state_reg <= ST_T0;
                        end else begin
                            x_reg <= {{32{fine_reg[31]}}, fine_reg} - FINE_OFFSET;
                            state_reg <= ST_P0;
                        end
                    end
                end
                ST_T0: begin
                    if (mul_take) begin
                        z_reg <= asr(mul_p, 6'd11);  // v1
                        state_reg <= ST_T1;
                    end
                end
                ST_T1: if (mul_take) state_reg <= ST_T2;
                ST_T2: begin
                    if (mul_take) begin
                        z_reg <= fine_sum;  // tf
                        fine_reg <= fine_sum[31:0];
                        state_reg <= ST_T3;
                    end
                end
                ST_T3: begin
                    if (mul_take) begin
                        out_value_reg <= temp_round[32:0];
                        out_zd_reg <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_P0: if (mul_take) begin w_reg <= mul_p; state_reg <= ST_P1; end
                ST_P1: begin
                    if (mul_take) begin
                        y_reg <= mul_p;  // v2 = v1*v1*P6
                        state_reg <= ST_P2;
                    end
                end
                ST_P2: begin
                    if (mul_take) begin
                        y_reg <= y_reg + (mul_p << 17) + (sx16(p45_reg[15:0]) << 35);
                        state_reg <= ST_P3;
                    end
                end
                ST_P3: begin
                    if (mul_take) begin
                        z_reg <= asr(mul_p, 6'd8);  // v1*v1*P3 >> 8
                        state_reg <= ST_P4;
                    end
                end
                ST_P4: begin
                    if (mul_take) begin
                        z_reg <= (64'd1 << 47) + z_reg + (mul_p << 12);
                        state_reg <= ST_P5;
                    end
                end
                ST_P5: begin
                    if (mul_take) begin
                        z_reg <= asr(mul_p, 6'd33);  // divisor
                        w_reg <= (((PRESS_FULL - {44'd0, adc_reg}) << 31) - y_reg);
                        state_reg <= ST_P6;
                    end
                end
                ST_P6: begin
                    // The divider starts on the same edge when the divisor is nonzero.
                    if (mul_take) begin
                        if (z_reg == '0) begin
                            out_value_reg <= '0;
                            out_zd_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        x_reg <= div_q;  // p
                        state_reg <= ST_Q0;
                    end
                end
                ST_Q0: if (mul_take) state_reg <= ST_Q1;
                ST_Q1: begin
                    if (mul_take) begin
                        y_reg <= asr(mul_p, 6'd25);
                        state_reg <= ST_Q2;
                    end
                end
                ST_Q2: begin
                    if (mul_take) begin
                        z_reg <= asr(x_reg + y_reg + asr(mul_p, 6'd19), 6'd8)
                                 + (sx16(p67_reg[31:16]) << 4);
                        state_reg <= ST_Q3;
                    end
                end
                ST_Q3: begin
                    out_zd_reg <= 1'b0;
                    if (z_reg[63]) out_value_reg <= '0;
                    else if (z_reg[63:32] != '0) out_value_reg <= 33'h0FFFFFFFF;
                    else out_value_reg <= {1'b0, z_reg[31:0]};
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // No new word is taken while a result is still held.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !s_axis_tready) else $error("accept while result held");
    // A flagged zero divisor always carries a zero value.
    a_zd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero divisor with nonzero value");
    // An accepted word moves the sequencer out of idle.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != ST_IDLE))
        else $error("sequencer did not start");
`endif
endmodule
